>>> rtl/ptpd_pkg.sv
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared constants, codes, command and status types for the point to polygon
// distance block.
// ----------------------------------------------------------------------------
package ptpd_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 32;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int OPW          = 2 * DIFF_W + 2;
   localparam int DIG_W        = 17;
   localparam int DIG_N        = OPW / DIG_W;
   localparam int STEP_W       = $clog2(DIG_N);
   localparam int PRODW        = 2 * OPW;
   localparam int ACCW         = PRODW + 1;
   localparam int SQW          = PRODW;
   localparam int DIST_W       = 32;
   localparam int BIT_W        = $clog2(DIST_W);
   localparam int SQ_INIT_SH   = 2 * (DIST_W - 1);
   localparam int PROG_W       = 4;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      SEL_PH_EV = 4'd0,
      SEL_PV_EH = 4'd1,
      SEL_EH_PH = 4'd2,
      SEL_EV_PV = 4'd3,
      SEL_EH_EH = 4'd4,
      SEL_EV_EV = 4'd5,
      SEL_PH_PH = 4'd6,
      SEL_PV_PV = 4'd7,
      SEL_WH_WH = 4'd8,
      SEL_WV_WV = 4'd9,
      SEL_CR_CR = 4'd10
   } mul_sel_type;

   typedef enum logic [2:0] {
      DEST_NONE = 3'd0,
      DEST_CR   = 3'd1,
      DEST_DOT  = 3'd2,
      DEST_D2   = 3'd3,
      DEST_NUM  = 3'd4
   } dest_type;

   typedef enum logic [1:0] {
      MODE_START_PT = 2'd0,
      MODE_END_PT   = 2'd1,
      MODE_SEGMENT  = 2'd2
   } mode_type;

   localparam logic [PROG_W-1:0] PROG_CROSS    = 4'd0;
   localparam logic [PROG_W-1:0] PROG_LEN_LAST = 4'd5;
   localparam logic [PROG_W-1:0] PROG_START_PT = 4'd6;
   localparam logic [PROG_W-1:0] PROG_END_PT   = 4'd8;
   localparam logic [PROG_W-1:0] PROG_SEGMENT  = 4'd10;

   typedef struct packed {
      mul_sel_type sel;
      logic        clear;
      logic        sub;
      dest_type    dest;
   } prog_type;

   typedef struct packed {
      logic                    wr_en;
      logic [ADDR_W-1:0]       wr_addr;
      logic [ADDR_W-1:0]       rd_addr;
      logic                    cap_q;
      logic                    cap_a;
      logic                    cap_b;
      logic                    mul_load;
      mul_sel_type             mul_sel;
      logic                    mul_clear;
      logic                    mul_sub;
      logic                    mul_step;
      logic                    mul_acc;
      dest_type                dest;
      logic                    walk_init;
      logic                    sq_init;
      logic                    sq_a;
      logic                    sq_b;
      logic [BIT_W-1:0]        sq_bit;
      logic                    edge_done;
      logic                    out_load;
      logic                    out_empty;
      logic                    out_ovf;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
   } stat_type;

   function automatic prog_type prog_entry(input logic [PROG_W-1:0] mop);
      prog_type p;
      p = '{sel: SEL_PH_EV, clear: 1'b0, sub: 1'b0, dest: DEST_NONE};
      case (mop)
         4'd0:    p = '{sel: SEL_PH_EV, clear: 1'b1, sub: 1'b1, dest: DEST_NONE};
         4'd1:    p = '{sel: SEL_PV_EH, clear: 1'b0, sub: 1'b0, dest: DEST_CR};
         4'd2:    p = '{sel: SEL_EH_PH, clear: 1'b1, sub: 1'b0, dest: DEST_NONE};
         4'd3:    p = '{sel: SEL_EV_PV, clear: 1'b0, sub: 1'b0, dest: DEST_DOT};
         4'd4:    p = '{sel: SEL_EH_EH, clear: 1'b1, sub: 1'b0, dest: DEST_NONE};
         4'd5:    p = '{sel: SEL_EV_EV, clear: 1'b0, sub: 1'b0, dest: DEST_D2};
         4'd6:    p = '{sel: SEL_PH_PH, clear: 1'b1, sub: 1'b0, dest: DEST_NONE};
         4'd7:    p = '{sel: SEL_PV_PV, clear: 1'b0, sub: 1'b0, dest: DEST_NUM};
         4'd8:    p = '{sel: SEL_WH_WH, clear: 1'b1, sub: 1'b0, dest: DEST_NONE};
         4'd9:    p = '{sel: SEL_WV_WV, clear: 1'b0, sub: 1'b0, dest: DEST_NUM};
         4'd10:   p = '{sel: SEL_CR_CR, clear: 1'b1, sub: 1'b0, dest: DEST_NUM};
         default: p = '{sel: SEL_PH_EV, clear: 1'b0, sub: 1'b0, dest: DEST_NONE};
      endcase
      return p;
   endfunction

endpackage

>>> rtl/ptpd_ram.sv
// ----------------------------------------------------------------------------
// ptpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptpd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ptpd_ctrl.sv
// ----------------------------------------------------------------------------
// ptpd_ctrl
// Controller: vertex loading, edge walk sequencing, multiply program,
// root search steps and result handshake.
// ----------------------------------------------------------------------------
module ptpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ptpd_pkg::cmd_type   cmd,
   input  ptpd_pkg::stat_type  stat
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b000000000001,
      ST_RD_A     = 12'b000000000010,
      ST_RD_B     = 12'b000000000100,
      ST_LD_B     = 12'b000000001000,
      ST_MUL_LOAD = 12'b000000010000,
      ST_MUL_STEP = 12'b000000100000,
      ST_MUL_ACC  = 12'b000001000000,
      ST_SEL      = 12'b000010000000,
      ST_SQ_A     = 12'b000100000000,
      ST_SQ_B     = 12'b001000000000,
      ST_EDGE     = 12'b010000000000,
      ST_FINISH   = 12'b100000000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ptpd_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              ovf_ff, ovf_in;
   logic [ptpd_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [ptpd_pkg::PROG_W-1:0]       mop_ff, mop_in;
   logic [ptpd_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [ptpd_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic                              accept;
   logic                              full;
   logic                              finish_go;
   logic [ptpd_pkg::CNT_W-1:0]        idx_inc;
   ptpd_pkg::prog_type                prog;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == ptpd_pkg::CNT_W'(ptpd_pkg::MAX_VERTICES));
   assign idx_inc   = idx_ff + 1'b1;
   assign prog      = ptpd_pkg::prog_entry(mop_ff);
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      mop_in       = mop_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      rsp_valid_in = finish_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      cmd          = '0;
      cmd.rd_addr  = idx_ff[ptpd_pkg::ADDR_W-1:0];
      cmd.sq_bit   = bit_ff;
      cmd.out_empty = (cnt_ff == '0);
      cmd.out_ovf  = ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ptpd_pkg::ACT_START: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = '0;
                     cnt_in      = ptpd_pkg::CNT_W'(1);
                     ovf_in      = 1'b0;
                  end
                  ptpd_pkg::ACT_APPEND: begin
                     if (full) begin
                        ovf_in = 1'b1;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = cnt_ff[ptpd_pkg::ADDR_W-1:0];
                        cnt_in      = cnt_ff + 1'b1;
                     end
                  end
                  ptpd_pkg::ACT_QUERY: begin
                     cmd.cap_q     = 1'b1;
                     cmd.walk_init = 1'b1;
                     idx_in        = '0;
                     state_in      = (cnt_ff == '0) ? ST_FINISH : ST_RD_A;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_addr = (idx_inc == cnt_ff) ? '0 : idx_inc[ptpd_pkg::ADDR_W-1:0];
            state_in    = ST_LD_B;
         end
         ST_LD_B: begin
            cmd.cap_b = 1'b1;
            mop_in    = ptpd_pkg::PROG_CROSS;
            state_in  = ST_MUL_LOAD;
         end
         ST_MUL_LOAD: begin
            cmd.mul_load  = 1'b1;
            cmd.mul_sel   = prog.sel;
            cmd.mul_clear = prog.clear;
            cmd.mul_sub   = prog.sub;
            step_in       = '0;
            state_in      = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ptpd_pkg::STEP_W'(ptpd_pkg::DIG_N - 1)) begin
               state_in = ST_MUL_ACC;
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_acc = 1'b1;
            cmd.dest    = prog.dest;
            if (prog.dest == ptpd_pkg::DEST_NUM) begin
               bit_in   = ptpd_pkg::BIT_W'(ptpd_pkg::DIST_W - 1);
               state_in = ST_SQ_A;
            end else if (mop_ff == ptpd_pkg::PROG_LEN_LAST) begin
               state_in = ST_SEL;
            end else begin
               mop_in   = mop_ff + 1'b1;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_SEL: begin
            cmd.sq_init = 1'b1;
            case (stat.mode)
               ptpd_pkg::MODE_START_PT: mop_in = ptpd_pkg::PROG_START_PT;
               ptpd_pkg::MODE_END_PT:   mop_in = ptpd_pkg::PROG_END_PT;
               default:                 mop_in = ptpd_pkg::PROG_SEGMENT;
            endcase
            state_in = ST_MUL_LOAD;
         end
         ST_SQ_A: begin
            cmd.sq_a = 1'b1;
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            cmd.sq_b = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_EDGE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_SQ_A;
            end
         end
         ST_EDGE: begin
            cmd.edge_done = 1'b1;
            if (idx_inc == cnt_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_RD_A;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         mop_ff       <= '0;
         step_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         mop_ff       <= mop_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transfer");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_FINISH) |-> (idx_ff < cnt_ff))
      else $error("edge index beyond vertex count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ptpd_pkg::ACT_APPEND && full)
      |=> (ovf_ff && $stable(cnt_ff)))
      else $error("vertex not dropped when store full");
`endif

endmodule

>>> rtl/ptpd_dp.sv
// ----------------------------------------------------------------------------
// ptpd_dp
// Datapath: vertex store, edge registers, digit serial multiply accumulate,
// incremental root search, edge reduction and result register.
// ----------------------------------------------------------------------------
module ptpd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  ptpd_pkg::cmd_type                    cmd,
   output ptpd_pkg::stat_type                   stat,
   output logic [ptpd_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                 rsp_inside_res,
   output logic                                 rsp_empty_polygon,
   output logic                                 rsp_vertex_overflow
);

   localparam int CW = ptpd_pkg::COORD_WIDTH;

   function automatic logic [ptpd_pkg::OPW-1:0] mag(input logic [ptpd_pkg::OPW-1:0] v);
      return v[ptpd_pkg::OPW-1] ? (~v + 1'b1) : v;
   endfunction

   logic [2*CW-1:0]                  rd_data;
   logic signed [CW-1:0]             qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CW-1:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic signed [CW-1:0]             bx_ff, bx_in, by_ff, by_in;

   logic signed [ptpd_pkg::DIFF_W-1:0] eh, ev, ph, pv, wh, wv;
   logic signed [ptpd_pkg::OPW-1:0]  op_a, op_b;

   logic [ptpd_pkg::OPW-1:0]         mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic                             mul_neg_ff, mul_neg_in, mul_clr_ff, mul_clr_in;
   logic [ptpd_pkg::PRODW-1:0]       prod_ff, prod_in;
   logic signed [ptpd_pkg::ACCW-1:0] acc_ff, acc_in;
   logic signed [ptpd_pkg::OPW-1:0]  cr_ff, cr_in, dot_ff, dot_in, d2_ff, d2_in;
   logic [ptpd_pkg::SQW-1:0]         num_ff, num_in;

   logic [ptpd_pkg::DIG_W-1:0]       digit;
   logic [ptpd_pkg::OPW+ptpd_pkg::DIG_W-1:0] pp;
   logic signed [ptpd_pkg::ACCW-1:0] acc_add, acc_sum;

   logic [ptpd_pkg::SQW-1:0]         p_ff, p_in, rs_ff, rs_in, ds_ff, ds_in, t_ff, t_in;
   logic [ptpd_pkg::DIST_W-1:0]      root_ff, root_in;
   logic [ptpd_pkg::SQW-1:0]         cand;
   logic                             fits;
   logic [ptpd_pkg::OPW-1:0]         den_sel;

   logic [ptpd_pkg::DIST_W-1:0]      best_ff, best_in;
   logic                             par_ff, par_in, on_ff, on_in;
   logic                             in_range, on_seg, hi_is_b, t_vert, t_cross, toggle;
   logic signed [CW-1:0]             hx, hy, lx;

   logic [ptpd_pkg::DIST_W-1:0]      dist_ff, dist_in;
   logic                             ins_ff, ins_in, emp_ff, emp_in, ovf_ff, ovf_in;

   ptpd_ram #(
      .WIDTH (2 * CW),
      .DEPTH (ptpd_pkg::MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign eh = ptpd_pkg::DIFF_W'(by_ff) - ptpd_pkg::DIFF_W'(ay_ff);
   assign ev = ptpd_pkg::DIFF_W'(bx_ff) - ptpd_pkg::DIFF_W'(ax_ff);
   assign ph = ptpd_pkg::DIFF_W'(qy_ff) - ptpd_pkg::DIFF_W'(ay_ff);
   assign pv = ptpd_pkg::DIFF_W'(qx_ff) - ptpd_pkg::DIFF_W'(ax_ff);
   assign wh = ptpd_pkg::DIFF_W'(qy_ff) - ptpd_pkg::DIFF_W'(by_ff);
   assign wv = ptpd_pkg::DIFF_W'(qx_ff) - ptpd_pkg::DIFF_W'(bx_ff);

   always_comb begin
      case (cmd.mul_sel)
         ptpd_pkg::SEL_PH_EV: begin op_a = ptpd_pkg::OPW'(ph); op_b = ptpd_pkg::OPW'(ev); end
         ptpd_pkg::SEL_PV_EH: begin op_a = ptpd_pkg::OPW'(pv); op_b = ptpd_pkg::OPW'(eh); end
         ptpd_pkg::SEL_EH_PH: begin op_a = ptpd_pkg::OPW'(eh); op_b = ptpd_pkg::OPW'(ph); end
         ptpd_pkg::SEL_EV_PV: begin op_a = ptpd_pkg::OPW'(ev); op_b = ptpd_pkg::OPW'(pv); end
         ptpd_pkg::SEL_EH_EH: begin op_a = ptpd_pkg::OPW'(eh); op_b = ptpd_pkg::OPW'(eh); end
         ptpd_pkg::SEL_EV_EV: begin op_a = ptpd_pkg::OPW'(ev); op_b = ptpd_pkg::OPW'(ev); end
         ptpd_pkg::SEL_PH_PH: begin op_a = ptpd_pkg::OPW'(ph); op_b = ptpd_pkg::OPW'(ph); end
         ptpd_pkg::SEL_PV_PV: begin op_a = ptpd_pkg::OPW'(pv); op_b = ptpd_pkg::OPW'(pv); end
         ptpd_pkg::SEL_WH_WH: begin op_a = ptpd_pkg::OPW'(wh); op_b = ptpd_pkg::OPW'(wh); end
         ptpd_pkg::SEL_WV_WV: begin op_a = ptpd_pkg::OPW'(wv); op_b = ptpd_pkg::OPW'(wv); end
         ptpd_pkg::SEL_CR_CR: begin op_a = cr_ff; op_b = cr_ff; end
         default:             begin op_a = '0; op_b = '0; end
      endcase
   end

   assign digit   = mul_b_ff[ptpd_pkg::OPW-1 -: ptpd_pkg::DIG_W];
   assign pp      = mul_a_ff * digit;
   assign acc_add = mul_neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
   assign acc_sum = (mul_clr_ff ? '0 : acc_ff) + acc_add;

   always_comb begin
      if (dot_ff[ptpd_pkg::OPW-1] || (dot_ff == '0)) begin
         stat.mode = ptpd_pkg::MODE_START_PT;
      end else if (dot_ff >= d2_ff) begin
         stat.mode = ptpd_pkg::MODE_END_PT;
      end else begin
         stat.mode = ptpd_pkg::MODE_SEGMENT;
      end
   end

   assign den_sel = (stat.mode == ptpd_pkg::MODE_SEGMENT) ? d2_ff : ptpd_pkg::OPW'(1);
   assign cand    = t_ff + ds_ff;
   assign fits    = (cand <= num_ff);

   assign in_range = (qy_ff >= ((ay_ff < by_ff) ? ay_ff : by_ff)) &&
                     (qy_ff <= ((ay_ff < by_ff) ? by_ff : ay_ff)) &&
                     (qx_ff >= ((ax_ff < bx_ff) ? ax_ff : bx_ff)) &&
                     (qx_ff <= ((ax_ff < bx_ff) ? bx_ff : ax_ff));
   assign on_seg   = in_range && (cr_ff == '0);
   assign hi_is_b  = (ax_ff < bx_ff);
   assign hx       = hi_is_b ? bx_ff : ax_ff;
   assign hy       = hi_is_b ? by_ff : ay_ff;
   assign lx       = hi_is_b ? ax_ff : bx_ff;
   assign t_vert   = (qx_ff == hx) && (qy_ff < hy);
   assign t_cross  = (qx_ff > lx) && (qx_ff < hx) &&
                     (hi_is_b ? (!cr_ff[ptpd_pkg::OPW-1] && (cr_ff != '0))
                              : cr_ff[ptpd_pkg::OPW-1]);
   assign toggle   = (ax_ff != bx_ff) && (t_vert ^ t_cross);

   always_comb begin
      qx_in      = cmd.cap_q ? req_coord_x : qx_ff;
      qy_in      = cmd.cap_q ? req_coord_y : qy_ff;
      ax_in      = cmd.cap_a ? rd_data[2*CW-1:CW] : ax_ff;
      ay_in      = cmd.cap_a ? rd_data[CW-1:0]    : ay_ff;
      bx_in      = cmd.cap_b ? rd_data[2*CW-1:CW] : bx_ff;
      by_in      = cmd.cap_b ? rd_data[CW-1:0]    : by_ff;

      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      mul_neg_in = mul_neg_ff;
      mul_clr_in = mul_clr_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      cr_in      = cr_ff;
      dot_in     = dot_ff;
      d2_in      = d2_ff;
      num_in     = num_ff;
      if (cmd.mul_load) begin
         mul_a_in   = mag(op_a);
         mul_b_in   = mag(op_b);
         mul_neg_in = op_a[ptpd_pkg::OPW-1] ^ op_b[ptpd_pkg::OPW-1] ^ cmd.mul_sub;
         mul_clr_in = cmd.mul_clear;
         prod_in    = '0;
      end
      if (cmd.mul_step) begin
         mul_b_in = mul_b_ff << ptpd_pkg::DIG_W;
         prod_in  = (prod_ff << ptpd_pkg::DIG_W) + ptpd_pkg::PRODW'(pp);
      end
      if (cmd.mul_acc) begin
         acc_in = acc_sum;
         case (cmd.dest)
            ptpd_pkg::DEST_CR:  cr_in  = acc_sum[ptpd_pkg::OPW-1:0];
            ptpd_pkg::DEST_DOT: dot_in = acc_sum[ptpd_pkg::OPW-1:0];
            ptpd_pkg::DEST_D2:  d2_in  = acc_sum[ptpd_pkg::OPW-1:0];
            ptpd_pkg::DEST_NUM: num_in = acc_sum[ptpd_pkg::SQW-1:0];
            default: begin
            end
         endcase
      end

      p_in    = p_ff;
      rs_in   = rs_ff;
      ds_in   = ds_ff;
      t_in    = t_ff;
      root_in = root_ff;
      if (cmd.sq_init) begin
         p_in    = '0;
         rs_in   = '0;
         ds_in   = ptpd_pkg::SQW'(den_sel) << ptpd_pkg::SQ_INIT_SH;
         root_in = '0;
      end
      if (cmd.sq_a) begin
         t_in = p_ff + rs_ff;
      end
      if (cmd.sq_b) begin
         ds_in = ds_ff >> 2;
         if (fits) begin
            p_in    = cand;
            rs_in   = (rs_ff >> 1) + ds_ff;
            root_in = root_ff | (ptpd_pkg::DIST_W'(1) << cmd.sq_bit);
         end else begin
            rs_in   = rs_ff >> 1;
         end
      end

      best_in = best_ff;
      par_in  = par_ff;
      on_in   = on_ff;
      if (cmd.walk_init) begin
         best_in = '1;
         par_in  = 1'b0;
         on_in   = 1'b0;
      end
      if (cmd.edge_done) begin
         best_in = (root_ff < best_ff) ? root_ff : best_ff;
         par_in  = par_ff ^ toggle;
         on_in   = on_ff | on_seg;
      end

      dist_in = dist_ff;
      ins_in  = ins_ff;
      emp_in  = emp_ff;
      ovf_in  = ovf_ff;
      if (cmd.out_load) begin
         emp_in  = cmd.out_empty;
         ovf_in  = cmd.out_ovf;
         ins_in  = !cmd.out_empty && (on_ff || par_ff);
         dist_in = (cmd.out_empty || on_ff || par_ff) ? '0 : best_ff;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_neg_ff <= mul_neg_in;
      mul_clr_ff <= mul_clr_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      cr_ff      <= cr_in;
      dot_ff     <= dot_in;
      d2_ff      <= d2_in;
      num_ff     <= num_in;
      p_ff       <= p_in;
      rs_ff      <= rs_in;
      ds_ff      <= ds_in;
      t_ff       <= t_in;
      root_ff    <= root_in;
      best_ff    <= best_in;
      dist_ff    <= dist_in;
      ins_ff     <= ins_in;
      emp_ff     <= emp_in;
      ovf_ff     <= ovf_in;
      if (reset) begin
         par_ff <= 1'b0;
         on_ff  <= 1'b0;
      end else begin
         par_ff <= par_in;
         on_ff  <= on_in;
      end
   end

   assign rsp_distance        = dist_ff;
   assign rsp_inside_res      = ins_ff;
   assign rsp_empty_polygon   = emp_ff;
   assign rsp_vertex_overflow = ovf_ff;

endmodule

>>> rtl/point_to_polygon_distance_top.sv
// Vertex load or ignored action: no transfer on the result side.
// Query: for each stored vertex the per-edge walk runs seven or eight 17-bit
// digit serial multiplies and a bit by bit root search; an empty polygon goes
// straight to the result. One item at a time.
// Reset (synchronous, active high) clears vertex count, overflow flag and
// handshake state; the vertex store holds no reset value.
// ----------------------------------------------------------------------------
// point_to_polygon_distance_top
// Point to polygon distance: vertex loading and inside/distance queries.
// ----------------------------------------------------------------------------
module point_to_polygon_distance_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_action,
   input  logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ptpd_pkg::DIST_W-1:0]             rsp_distance,
   output logic                                    rsp_inside_res,
   output logic                                    rsp_empty_polygon,
   output logic                                    rsp_vertex_overflow
);

   ptpd_pkg::cmd_type  cmd;
   ptpd_pkg::stat_type stat;

   ptpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   ptpd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_distance        (rsp_distance),
      .rsp_inside_res      (rsp_inside_res),
      .rsp_empty_polygon   (rsp_empty_polygon),
      .rsp_vertex_overflow (rsp_vertex_overflow)
   );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the point to polygon distance block. Polygons are loaded and then
// queried. Each query result is compared field by field with a fixed answer
// from the directed table or with an in-bench predictor that works in wide
// exact integer arithmetic. A short directed table comes first, then random
// polygons with random queries. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  N_RANDOM = 1750;
   localparam longint LIMIT = 60000000;

   typedef logic signed [255:0] wide_t;

   typedef struct {
      ptpd_pkg::action_type act;
      logic [31:0] cx;
      logic [31:0] cy;
      bit          fixed;
      logic [31:0] e_dist;
      bit          e_in;
      bit          e_empty;
      bit          e_ovf;
   } row_t;

   typedef struct {
      logic [31:0] dist_val;
      bit          ins;
      bit          empty;
      bit          ovf;
   } answer_t;

   typedef struct {
      longint y;
      longint x;
   } pt_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ptpd_pkg::ACT_NONE;
   logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_x = '0;
   logic signed [ptpd_pkg::COORD_WIDTH-1:0] req_coord_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [ptpd_pkg::DIST_W-1:0] rsp_distance;
   logic        rsp_inside_res;
   logic        rsp_empty_polygon;
   logic        rsp_vertex_overflow;

   row_t    stim[$];
   answer_t pending_answers[$];
   longint  vert_x[ptpd_pkg::MAX_VERTICES];
   longint  vert_y[ptpd_pkg::MAX_VERTICES];
   int      vert_count = 0;
   bit      vert_dropped = 0;
   int      accepted = 0;
   int      mismatches = 0;
   int      queries_seen = 0;
   int      inside_seen = 0;
   int      overflow_seen_cnt = 0;
   longint  cycles = 0;
   bit      calm = 0;
   int      rsp_stall = 0;

   point_to_polygon_distance_top dut (.*);

   always #2 clock = ~clock;

   function automatic wide_t wmul(longint a, longint b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   function automatic logic [31:0] root_floor(wide_t num, wide_t den);
      logic [31:0] q, t;
      wide_t tw;
      q = 0;
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
         t = q | (32'd1 << bit_i);
         tw = {224'd0, t};
         if (tw * tw * den <= num) q = t;
      end
      return q;
   endfunction

   function automatic logic [31:0] pt_dist(pt_t a, pt_t q);
      longint dy, dx;
      dy = q.y - a.y;
      dx = q.x - a.x;
      return root_floor(wmul(dy, dy) + wmul(dx, dx), wide_t'(1));
   endfunction

   function automatic logic [31:0] edge_dist(pt_t a, pt_t b, pt_t q);
      longint ey, ex, py, px;
      wide_t dot, d2, cr;
      ey = b.y - a.y;
      ex = b.x - a.x;
      py = q.y - a.y;
      px = q.x - a.x;
      dot = wmul(ey, py) + wmul(ex, px);
      if (dot <= 0) return pt_dist(a, q);
      d2 = wmul(ey, ey) + wmul(ex, ex);
      if (dot >= d2) return pt_dist(b, q);
      cr = wmul(ey, px) - wmul(ex, py);
      return root_floor(cr * cr, d2);
   endfunction

   function automatic bit on_edge(pt_t a, pt_t b, pt_t q);
      longint ylo, yhi, xlo, xhi;
      ylo = (a.y < b.y) ? a.y : b.y;
      yhi = (a.y < b.y) ? b.y : a.y;
      xlo = (a.x < b.x) ? a.x : b.x;
      xhi = (a.x < b.x) ? b.x : a.x;
      if (q.y < ylo || q.y > yhi || q.x < xlo || q.x > xhi) return 0;
      return wmul(q.y - a.y, b.x - a.x) == wmul(q.x - a.x, b.y - a.y);
   endfunction

   function automatic pt_t corner(int i);
      pt_t p;
      p.y = vert_y[i];
      p.x = vert_x[i];
      return p;
   endfunction

   function automatic bit covers(pt_t q);
      bit par;
      pt_t a, b, lo, hi;
      par = 0;
      for (int i = 0; i < vert_count; i++) begin
         a = corner(i);
         b = corner((i + 1 == vert_count) ? 0 : i + 1);
         if (on_edge(a, b, q)) return 1;
         if (a.x == b.x) continue;
         if (a.x < b.x) begin
            lo = a; hi = b;
         end else begin
            lo = b; hi = a;
         end
         if (q.x == hi.x && q.y < hi.y) par = !par;
         if (q.x == lo.x && q.y < lo.y) continue;
         if (q.x > lo.x && q.x < hi.x) begin
            if (wmul(q.y - lo.y, hi.x - lo.x) < wmul(hi.y - lo.y, q.x - lo.x))
               par = !par;
         end
      end
      return par;
   endfunction

   function automatic answer_t polygon_distance(logic [31:0] cx, logic [31:0] cy);
      answer_t r;
      pt_t q;
      logic [31:0] d;
      r.ovf = vert_dropped;
      r.empty = 0;
      r.ins = 0;
      r.dist_val = 0;
      if (vert_count == 0) begin
         r.empty = 1;
         return r;
      end
      q.y = longint'($signed(cy));
      q.x = longint'($signed(cx));
      r.ins = covers(q);
      if (!r.ins) begin
         r.dist_val = 32'hFFFF_FFFF;
         for (int i = 0; i < vert_count; i++) begin
            d = edge_dist(corner(i), corner((i + 1 == vert_count) ? 0 : i + 1), q);
            if (d < r.dist_val) r.dist_val = d;
         end
      end
      return r;
   endfunction

   function automatic void load_vertex(row_t r);
      answer_t a;
      case (r.act)
         ptpd_pkg::ACT_START: begin
            vert_x[0] = longint'($signed(r.cx));
            vert_y[0] = longint'($signed(r.cy));
            vert_count = 1;
            vert_dropped = 0;
         end
         ptpd_pkg::ACT_APPEND: begin
            if (vert_count < ptpd_pkg::MAX_VERTICES) begin
               vert_x[vert_count] = longint'($signed(r.cx));
               vert_y[vert_count] = longint'($signed(r.cy));
               vert_count++;
            end else begin
               vert_dropped = 1;
            end
         end
         ptpd_pkg::ACT_QUERY: begin
            a = polygon_distance(r.cx, r.cy);
            if (r.fixed) begin
               a.dist_val = r.e_dist;
               a.ins = r.e_in;
               a.empty = r.e_empty;
               a.ovf = r.e_ovf;
            end
            pending_answers = {pending_answers, a};
         end
         default: ;
      endcase
   endfunction

   function automatic void add(ptpd_pkg::action_type act, logic [31:0] cx, logic [31:0] cy);
      row_t r;
      r = '{act, cx, cy, 0, 0, 0, 0, 0};
      stim = {stim, r};
   endfunction

   function automatic void add_fixed(logic [31:0] cx, logic [31:0] cy,
                                     logic [31:0] d, bit ins, bit emp, bit ovf);
      row_t r;
      r = '{ptpd_pkg::ACT_QUERY, cx, cy, 1, d, ins, emp, ovf};
      stim = {stim, r};
   endfunction

   function automatic logic [31:0] coord(int scale, logic [31:0] base);
      case (scale)
         0:       return base + $urandom_range(0, 8191) - 4096;
         1:       return (base & ~32'hFF) + 256 * ($urandom_range(0, 16) - 8);
         default: return $urandom;
      endcase
   endfunction

   function automatic void build_directed();
      add_fixed(0, 0, 0, 0, 1, 0);
      add(ptpd_pkg::ACT_START, 0, 0);
      add_fixed(768, 0, 768, 0, 0, 0);
      add(ptpd_pkg::ACT_APPEND, 1024, 0);
      add(ptpd_pkg::ACT_APPEND, 1024, 1024);
      add(ptpd_pkg::ACT_APPEND, 0, 1024);
      add_fixed(512, 512, 0, 1, 0, 0);
      add_fixed(0, 512, 0, 1, 0, 0);
      add_fixed(1024, 1024, 0, 1, 0, 0);
      add_fixed(2048, 512, 1024, 0, 0, 0);
      add_fixed(-256, -256, 362, 0, 0, 0);
      add_fixed(512, -1, 1, 0, 0, 0);
      add_fixed(1024, -512, 512, 0, 0, 0);
      add(ptpd_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_fixed(0, 2048, 1024, 0, 0, 0);
      add(ptpd_pkg::ACT_START, 0, 0);
      add(ptpd_pkg::ACT_APPEND, 2048, 1024);
      add(ptpd_pkg::ACT_APPEND, 0, 2048);
      add(ptpd_pkg::ACT_QUERY, 2048, 0);
      add(ptpd_pkg::ACT_QUERY, 1024, 1024);
      add(ptpd_pkg::ACT_QUERY, -512, 1024);
      add(ptpd_pkg::ACT_START, 32'h8000_0000, 32'h8000_0000);
      add_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      add(ptpd_pkg::ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add(ptpd_pkg::ACT_QUERY, 32'h7FFF_FFFF, 32'h8000_0000);
   endfunction

   function automatic void build_random();
      int scale, k, nq;
      logic [31:0] bx, by;
      while (stim.size() < N_RANDOM) begin
         if ($urandom_range(0, 19) == 0) begin
            add(ptpd_pkg::action_type'($urandom_range(0, 3)), $urandom, $urandom);
            continue;
         end
         k = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 68) : $urandom_range(0, 6);
         nq = $urandom_range(1, 4);
         scale = $urandom_range(0, 9);
         scale = (scale < 6) ? 0 : (scale < 8) ? 1 : 2;
         bx = (scale == 2) ? 0 : $urandom_range(0, 65535) - 32768;
         by = (scale == 2) ? 0 : $urandom_range(0, 65535) - 32768;
         if ($urandom_range(0, 9) != 0)
            add(ptpd_pkg::ACT_START, coord(scale, bx), coord(scale, by));
         for (int i = 0; i < k; i++)
            add(ptpd_pkg::ACT_APPEND, coord(scale, bx), coord(scale, by));
         for (int i = 0; i < nq; i++) begin
            if ($urandom_range(0, 7) == 0 && stim.size() > 0 &&
                stim[$].act != ptpd_pkg::ACT_NONE)
               add(ptpd_pkg::ACT_QUERY, stim[$].cx, stim[$].cy);
            else
               add(ptpd_pkg::ACT_QUERY, coord(scale, bx), coord(scale, by));
         end
      end
   endfunction

   always @(posedge clock) begin
      answer_t e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) begin
            load_vertex(stim[accepted]);
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result transfer at cycle %0d", cycles);
            end else begin
               e = pending_answers.pop_front();
               queries_seen++;
               if (rsp_inside_res) inside_seen++;
               if (rsp_vertex_overflow) overflow_seen_cnt++;
               if (rsp_distance !== e.dist_val || rsp_inside_res !== e.ins ||
                   rsp_empty_polygon !== e.empty || rsp_vertex_overflow !== e.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result %0d: expected dist %h in %b empty %b ovf %b, got %h %b %b %b",
                              queries_seen, e.dist_val, e.ins, e.empty, e.ovf, rsp_distance,
                              rsp_inside_res, rsp_empty_polygon, rsp_vertex_overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = $urandom_range(1, 18) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int gap;
      build_directed();
      build_random();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (stim[i]) begin
         if (i > stim.size() * 9 / 10) calm = 1;
         if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_action <= stim[i].act;
         req_coord_x <= stim[i].cx;
         req_coord_y <= stim[i].cy;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d items, %0d query results (%0d inside, %0d with dropped vertices)",
               stim.size(), queries_seen, inside_seen, overflow_seen_cnt);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ptpd_pkg.sv
rtl/ptpd_ram.sv
rtl/ptpd_ctrl.sv
rtl/ptpd_dp.sv
rtl/point_to_polygon_distance_top.sv
tb/testbench.sv
